>>> hw/rtl/closest_point_on_polyline_core_defines.svh
// Assertion macros shared by the closest-point polyline RTL.
// Depends on nothing; files that assert include it by name and need clk_i and rst_ni.
`ifndef CLOSEST_POINT_ON_POLYLINE_CORE_DEFINES_SVH
`define CLOSEST_POINT_ON_POLYLINE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, switched off while reset is held.
`define CPOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property that must also hold while reset is held.
`define CPOP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CPOP_ASSERT(lbl, prop, msg)
`define CPOP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/cpop_pkg.sv
// Shared types for the closest-point polyline core.
// Depends on nothing; used by the front end, the back end and the top level.
package cpop_pkg;

  // Per-transaction control flags passed from the front end to the back end.
  typedef struct packed {
    logic first;    // Starts a new polyline: the running best is cleared.
    logic last;     // Final vertex: a result follows this transaction.
    logic has_seg;  // A segment from the stored vertex to this vertex exists.
  } cpop_flags_t;

  localparam int unsigned FLAGS_W = $bits(cpop_flags_t);

endpackage

>>> hw/rtl/cpop_fifo.sv
// Small job queue between the front end and the back end of the polyline core.
// Depends on closest_point_on_polyline_core_defines.svh for its assertions.
`include "closest_point_on_polyline_core_defines.svh"

module cpop_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CPOP_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
  `CPOP_ASSERT(a_no_push_full, push_i |-> !full_o, "push into a full queue")
  `CPOP_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from an empty queue")

endmodule

>>> hw/rtl/cpop_front.sv
// Front end of the polyline core: accepts vertices and turns each into a segment job.
// Depends on cpop_pkg for the job flag type.
module cpop_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         first_vertex_i,
  input  logic                         last_vertex_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output logic signed [COORD_BITS-1:0] job_qx_o,
  output logic signed [COORD_BITS-1:0] job_qy_o,
  output logic signed [COORD_BITS-1:0] job_px_o,
  output logic signed [COORD_BITS-1:0] job_py_o,
  output logic signed [COORD_BITS-1:0] job_ex_o,
  output logic signed [COORD_BITS-1:0] job_ey_o,
  output cpop_pkg::cpop_flags_t        job_flags_o
);

  import cpop_pkg::*;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_x_d;
  logic signed [COORD_BITS-1:0] prev_y_q, prev_y_d;
  logic                         have_prev_q, have_prev_d;
  logic                         accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  // The segment runs from the stored vertex to the incoming one.
  assign job_qx_o = query_x_i;
  assign job_qy_o = query_y_i;
  assign job_px_o = prev_x_q;
  assign job_py_o = prev_y_q;
  assign job_ex_o = vertex_x_i;
  assign job_ey_o = vertex_y_i;

  always_comb begin
    job_flags_o.first   = first_vertex_i;
    job_flags_o.last    = last_vertex_i;
    job_flags_o.has_seg = have_prev_q && !first_vertex_i;
  end

  always_comb begin
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      prev_x_d    = vertex_x_i;
      prev_y_d    = vertex_y_i;
      // The polyline ends with its last vertex, so no segment starts there.
      have_prev_d = !last_vertex_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else begin
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
  end

endmodule

>>> hw/rtl/cpop_back.sv
// Back end of the polyline core: projects, divides, measures and keeps the nearest point.
// Depends on cpop_pkg and on closest_point_on_polyline_core_defines.svh.
`include "closest_point_on_polyline_core_defines.svh"

module cpop_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_pop_o,
  input  logic signed [COORD_BITS-1:0] job_qx_i,
  input  logic signed [COORD_BITS-1:0] job_qy_i,
  input  logic signed [COORD_BITS-1:0] job_px_i,
  input  logic signed [COORD_BITS-1:0] job_py_i,
  input  logic signed [COORD_BITS-1:0] job_ex_i,
  input  logic signed [COORD_BITS-1:0] job_ey_i,
  input  cpop_pkg::cpop_flags_t        job_flags_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] closest_x_o,
  output logic signed [COORD_BITS-1:0] closest_y_o,
  output logic                         found_o,
  output logic [2*COORD_BITS:0]        min_dist_sq_o
);

  import cpop_pkg::*;

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned D_W   = CW + 1;      // coordinate differences
  localparam int unsigned P_W   = 2 * CW + 2;  // signed products of differences
  localparam int unsigned S_W   = 2 * CW + 3;  // signed sums of two products
  localparam int unsigned L_W   = 2 * CW + 1;  // squared length, dot, remainder
  localparam int unsigned PL_W  = 2 * CW;      // low partial product
  localparam int unsigned BD_W  = 2 * CW + 2;  // running best distance
  localparam int unsigned CNT_W = $clog2(CW + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PROD  = 10'b0000000010,
    S_CLASS = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_SUMP  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_CPT   = 10'b0001000000,
    S_DPROD = 10'b0010000000,
    S_UPD   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } back_state_e;

  back_state_e state_q, state_d;

  // Job registers.
  logic signed [CW-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic signed [CW-1:0]  px_q, px_d, py_q, py_d;
  logic signed [CW-1:0]  ex_q, ex_d, ey_q, ey_d;
  cpop_flags_t           flags_q, flags_d;

  // Datapath registers.
  logic signed [D_W-1:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [P_W-1:0] pdx_q, pdx_d, pdy_q, pdy_d;
  logic signed [P_W-1:0] plx_q, plx_d, ply_q, ply_d;
  logic [L_W-1:0]        dot_q, dot_d, len2_q, len2_d;
  logic [PL_W-1:0]       pplo_x_q, pplo_x_d, pplo_y_q, pplo_y_d;
  logic [L_W-1:0]        pphi_x_q, pphi_x_d, pphi_y_q, pphi_y_d;
  logic [L_W-1:0]        rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [CW-1:0]         sh_x_q, sh_x_d, sh_y_q, sh_y_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [CW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [L_W-1:0]        sqx_q, sqx_d, sqy_q, sqy_d;

  // Running best.
  logic [BD_W-1:0]       best_dist_q, best_dist_d;
  logic signed [CW-1:0]  best_x_q, best_x_d, best_y_q, best_y_d;
  logic                  have_best_q, have_best_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic signed [CW-1:0]  res_x_q, res_x_d, res_y_q, res_y_d;
  logic                  res_found_q, res_found_d;
  logic [L_W-1:0]        res_dist_q, res_dist_d;

  // Combinational helpers.
  logic signed [D_W-1:0] vx_c, vy_c, wx_c, wy_c;
  logic signed [S_W-1:0] dot_c, len_c;
  logic signed [D_W-1:0] nvx_c, nvy_c;
  logic [CW-1:0]         mag_x_c, mag_y_c;
  logic [L_W:0]          tr_x_c, tr_y_c, df_x_c, df_y_c;
  logic                  ge_x_c, ge_y_c;
  logic signed [D_W-1:0] qext_x_c, qext_y_c, cxs_c, cys_c;
  logic signed [D_W-1:0] dx_c, dy_c;
  logic signed [P_W-1:0] sqx_c, sqy_c;
  logic [BD_W-1:0]       dist_c;
  logic                  load_out;

  always_comb begin
    vx_c  = D_W'(ex_q) - D_W'(px_q);
    vy_c  = D_W'(ey_q) - D_W'(py_q);
    wx_c  = D_W'(qx_q) - D_W'(px_q);
    wy_c  = D_W'(qy_q) - D_W'(py_q);
    dot_c = S_W'(pdx_q) + S_W'(pdy_q);
    len_c = S_W'(plx_q) + S_W'(ply_q);

    // Magnitudes of the segment vector; they never exceed the coordinate range.
    nvx_c   = -vx_q;
    nvy_c   = -vy_q;
    mag_x_c = vx_q[CW] ? nvx_c[CW-1:0] : vx_q[CW-1:0];
    mag_y_c = vy_q[CW] ? nvy_c[CW-1:0] : vy_q[CW-1:0];

    // One restoring division step per axis.
    tr_x_c = {rem_x_q, sh_x_q[CW-1]};
    tr_y_c = {rem_y_q, sh_y_q[CW-1]};
    df_x_c = tr_x_c - {1'b0, len2_q};
    df_y_c = tr_y_c - {1'b0, len2_q};
    ge_x_c = (tr_x_c >= {1'b0, len2_q});
    ge_y_c = (tr_y_c >= {1'b0, len2_q});

    // The quotient magnitude takes the sign of the segment vector.
    qext_x_c = $signed({1'b0, sh_x_q});
    qext_y_c = $signed({1'b0, sh_y_q});
    cxs_c    = vx_q[CW] ? D_W'(px_q) - qext_x_c : D_W'(px_q) + qext_x_c;
    cys_c    = vy_q[CW] ? D_W'(py_q) - qext_y_c : D_W'(py_q) + qext_y_c;

    dx_c   = D_W'(cx_q) - D_W'(qx_q);
    dy_c   = D_W'(cy_q) - D_W'(qy_q);
    sqx_c  = P_W'(dx_c) * P_W'(dx_c);
    sqy_c  = P_W'(dy_c) * P_W'(dy_c);
    dist_c = BD_W'(sqx_q) + BD_W'(sqy_q);
  end

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign load_out  = (state_q == S_FIN) && flags_q.last && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    px_d        = px_q;
    py_d        = py_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    flags_d     = flags_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    pdx_d       = pdx_q;
    pdy_d       = pdy_q;
    plx_d       = plx_q;
    ply_d       = ply_q;
    dot_d       = dot_q;
    len2_d      = len2_q;
    pplo_x_d    = pplo_x_q;
    pplo_y_d    = pplo_y_q;
    pphi_x_d    = pphi_x_q;
    pphi_y_d    = pphi_y_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    sh_x_d      = sh_x_q;
    sh_y_d      = sh_y_q;
    cnt_d       = cnt_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    best_dist_d = best_dist_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    have_best_d = have_best_q;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          qx_d    = job_qx_i;
          qy_d    = job_qy_i;
          px_d    = job_px_i;
          py_d    = job_py_i;
          ex_d    = job_ex_i;
          ey_d    = job_ey_i;
          flags_d = job_flags_i;
          if (job_flags_i.first) begin
            best_dist_d = '1;
            best_x_d    = '0;
            best_y_d    = '0;
            have_best_d = 1'b0;
          end
          state_d = job_flags_i.has_seg ? S_PROD : S_FIN;
        end
      end
      S_PROD: begin
        vx_d    = vx_c;
        vy_d    = vy_c;
        pdx_d   = P_W'(vx_c) * P_W'(wx_c);
        pdy_d   = P_W'(vy_c) * P_W'(wy_c);
        plx_d   = P_W'(vx_c) * P_W'(vx_c);
        ply_d   = P_W'(vy_c) * P_W'(vy_c);
        state_d = S_CLASS;
      end
      S_CLASS: begin
        dot_d  = dot_c[L_W-1:0];
        len2_d = len_c[L_W-1:0];
        if (dot_c[S_W-1] || (len_c == '0)) begin
          // Behind the start vertex, or a zero-length segment.
          cx_d    = px_q;
          cy_d    = py_q;
          state_d = S_DPROD;
        end else if (dot_c > len_c) begin
          cx_d    = ex_q;
          cy_d    = ey_q;
          state_d = S_DPROD;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // The product |v| * dot is split into two partial products per axis.
        pplo_x_d = PL_W'(mag_x_c) * PL_W'(dot_q[CW-1:0]);
        pplo_y_d = PL_W'(mag_y_c) * PL_W'(dot_q[CW-1:0]);
        pphi_x_d = L_W'(mag_x_c) * L_W'(dot_q[L_W-1:CW]);
        pphi_y_d = L_W'(mag_y_c) * L_W'(dot_q[L_W-1:CW]);
        state_d  = S_SUMP;
      end
      S_SUMP: begin
        // The upper part of the dividend is already below the divisor, so
        // only the low coordinate-width bits produce quotient bits.
        rem_x_d = pphi_x_q + L_W'(pplo_x_q[PL_W-1:CW]);
        rem_y_d = pphi_y_q + L_W'(pplo_y_q[PL_W-1:CW]);
        sh_x_d  = pplo_x_q[CW-1:0];
        sh_y_d  = pplo_y_q[CW-1:0];
        cnt_d   = CNT_W'(CW);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_x_d = ge_x_c ? df_x_c[L_W-1:0] : tr_x_c[L_W-1:0];
        rem_y_d = ge_y_c ? df_y_c[L_W-1:0] : tr_y_c[L_W-1:0];
        sh_x_d  = {sh_x_q[CW-2:0], ge_x_c};
        sh_y_d  = {sh_y_q[CW-2:0], ge_y_c};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_CPT;
        end
      end
      S_CPT: begin
        cx_d    = cxs_c[CW-1:0];
        cy_d    = cys_c[CW-1:0];
        state_d = S_DPROD;
      end
      S_DPROD: begin
        sqx_d   = sqx_c[L_W-1:0];
        sqy_d   = sqy_c[L_W-1:0];
        state_d = S_UPD;
      end
      S_UPD: begin
        // Only a strictly smaller distance replaces the current best.
        if (dist_c < best_dist_q) begin
          best_dist_d = dist_c;
          best_x_d    = cx_q;
          best_y_d    = cy_q;
          have_best_d = 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!flags_q.last) begin
          state_d = S_IDLE;
        end else if (load_out) begin
          best_dist_d = '1;
          best_x_d    = '0;
          best_y_d    = '0;
          have_best_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    res_found_d = res_found_q;
    res_dist_d  = res_dist_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      res_found_d = have_best_q;
      if (have_best_q) begin
        res_x_d    = best_x_q;
        res_y_d    = best_y_q;
        res_dist_d = best_dist_q[L_W-1:0];
      end else begin
        res_x_d    = qx_q;
        res_y_d    = qy_q;
        res_dist_d = '0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      best_dist_q <= '1;
      best_x_q    <= '0;
      best_y_q    <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      best_dist_q <= best_dist_d;
      best_x_q    <= best_x_d;
      best_y_q    <= best_y_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q        <= qx_d;
    qy_q        <= qy_d;
    px_q        <= px_d;
    py_q        <= py_d;
    ex_q        <= ex_d;
    ey_q        <= ey_d;
    flags_q     <= flags_d;
    vx_q        <= vx_d;
    vy_q        <= vy_d;
    pdx_q       <= pdx_d;
    pdy_q       <= pdy_d;
    plx_q       <= plx_d;
    ply_q       <= ply_d;
    dot_q       <= dot_d;
    len2_q      <= len2_d;
    pplo_x_q    <= pplo_x_d;
    pplo_y_q    <= pplo_y_d;
    pphi_x_q    <= pphi_x_d;
    pphi_y_q    <= pphi_y_d;
    rem_x_q     <= rem_x_d;
    rem_y_q     <= rem_y_d;
    sh_x_q      <= sh_x_d;
    sh_y_q      <= sh_y_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    sqx_q       <= sqx_d;
    sqy_q       <= sqy_d;
    res_x_q     <= res_x_d;
    res_y_q     <= res_y_d;
    res_found_q <= res_found_d;
    res_dist_q  <= res_dist_d;
  end

  assign out_valid_o   = out_valid_q;
  assign closest_x_o   = res_x_q;
  assign closest_y_o   = res_y_q;
  assign found_o       = res_found_q;
  assign min_dist_sq_o = res_dist_q;

  `CPOP_ASSERT(a_state_onehot, $onehot(state_q), "back-end state is not one-hot")
  `CPOP_ASSERT(a_rem_below_divisor,
               (state_q == S_DIV) |-> (rem_x_q < len2_q) && (rem_y_q < len2_q),
               "division remainder not below squared length")
  `CPOP_ASSERT(a_out_hold,
               out_valid_q && out_stall_i |=> out_valid_q &&
                 $stable({res_x_q, res_y_q, res_found_q, res_dist_q}),
               "stalled result changed")

endmodule

>>> hw/rtl/closest_point_on_polyline_core.sv
// Top level of the closest-point-on-polyline core.
// Depends on cpop_pkg, cpop_front, cpop_fifo and cpop_back.

// The core takes one polyline vertex per input transaction, together with the
// query point, and returns one result transaction on the vertex flagged as
// last: the nearest point of the polyline to the query, whether any segment
// existed, and the squared distance as an unsigned integer (Q33.0 for 16-bit
// coordinates). A polyline with a single vertex returns the query point with
// found cleared and a zero distance. The front end accepts vertices into a
// small job queue and can run ahead of the back end by the queue depth. The
// back end works on one segment at a time; its cost is set by the per-axis
// restoring divider that places the projection inside the segment. Such a
// segment passes the multiply and division steps; a segment clamped to an end
// vertex skips them, and a vertex that closes no segment goes straight to the
// finish. A finished result sits in an output register, so the back end goes
// on with the next job unless a second result waits behind a stalled one.
// No memory needs clearing after reset.
module closest_point_on_polyline_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         first_vertex_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] closest_x_o,
  output logic signed [COORD_BITS-1:0] closest_y_o,
  output logic                         found_o,
  output logic [2*COORD_BITS:0]        min_dist_sq_o
);

  import cpop_pkg::*;

  // A queued job holds the query, both segment ends and the control flags.
  localparam int unsigned JOB_W = 6 * COORD_BITS + FLAGS_W;

  logic                         push, queue_full, queue_empty, pop;
  logic signed [COORD_BITS-1:0] f_qx, f_qy, f_px, f_py, f_ex, f_ey;
  cpop_flags_t                  f_flags;
  logic [JOB_W-1:0]             push_data, pop_data;
  logic signed [COORD_BITS-1:0] b_qx, b_qy, b_px, b_py, b_ex, b_ey;
  cpop_flags_t                  b_flags;

  cpop_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .job_qx_o       (f_qx),
    .job_qy_o       (f_qy),
    .job_px_o       (f_px),
    .job_py_o       (f_py),
    .job_ex_o       (f_ex),
    .job_ey_o       (f_ey),
    .job_flags_o    (f_flags)
  );

  assign push_data = {f_qx, f_qy, f_px, f_py, f_ex, f_ey, f_flags};

  cpop_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (queue_empty)
  );

  assign {b_qx, b_qy, b_px, b_py, b_ex, b_ey, b_flags} = pop_data;

  cpop_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!queue_empty),
    .job_pop_o     (pop),
    .job_qx_i      (b_qx),
    .job_qy_i      (b_qy),
    .job_px_i      (b_px),
    .job_py_i      (b_py),
    .job_ex_i      (b_ex),
    .job_ey_i      (b_ey),
    .job_flags_i   (b_flags),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .closest_x_o   (closest_x_o),
    .closest_y_o   (closest_y_o),
    .found_o       (found_o),
    .min_dist_sq_o (min_dist_sq_o)
  );

endmodule
